### hdl/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants of the quoted token splitter
// Character codes, result kinds, error codes, parse modes, the parse state and the result record.
// ----------------------------------------------------------------------------
package qts_pkg;

    localparam int MAX_TOKEN_LIMIT = 4096;
    localparam int LEN_W           = 13;
    localparam int COUNT_W         = 16;

    localparam logic [COUNT_W-1:0] COUNT_CAP = 16'hFFFF;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_NO_QUOTE = 2'd2;

    typedef enum logic [4:0] {
        MODE_SKIP   = 5'b00001,
        MODE_PLAIN  = 5'b00010,
        MODE_QUOTED = 5'b00100,
        MODE_QPEND  = 5'b01000,
        MODE_DRAIN  = 5'b10000
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [LEN_W-1:0]   raw_len;
        logic [COUNT_W-1:0] tokens;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         out_byte;
        logic [COUNT_W-1:0] token_count;
        logic [1:0]         error_code;
        logic               last_of_run;
    } result_t;

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] b,
                                            logic [COUNT_W-1:0] cnt, logic [1:0] err);
        result_t r;
        r.kind        = kind;
        r.out_byte    = b;
        r.token_count = cnt;
        r.error_code  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

### hdl/qts_step.sv
// ----------------------------------------------------------------------------
// qts_step: per-byte parse step
// From the current state and one input byte, produces up to three results and
// the next parse state.
// ----------------------------------------------------------------------------
module qts_step (
    input  qts_pkg::parse_state_t       cur,
    input  logic [7:0]                  in_byte,
    input  logic                        last,
    input  logic [qts_pkg::LEN_W-1:0]   max_len,
    output qts_pkg::parse_state_t       nxt,
    output qts_pkg::result_t            res [3],
    output logic [1:0]                  res_cnt
);
    import qts_pkg::*;

    logic [LEN_W-1:0]   lim;
    logic               is_sep;
    logic               is_quote;
    mode_t              mode;
    logic [LEN_W-1:0]   raw;
    logic [COUNT_W-1:0] cnt;
    logic [1:0]         n;
    logic               done;
    logic               do_end;

    assign lim      = (max_len > LEN_W'(MAX_TOKEN_LIMIT)) ? LEN_W'(MAX_TOKEN_LIMIT) : max_len;
    assign is_sep   = (in_byte == CHR_SPACE) || (in_byte == CHR_TAB) || (in_byte == CHR_LF);
    assign is_quote = (in_byte == CHR_QUOTE);

    always_comb
    begin
        mode   = cur.mode;
        raw    = cur.raw_len;
        cnt    = cur.tokens;
        n      = 2'd0;
        done   = 1'b0;
        do_end = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end

        if (in_byte == CHR_NUL)
        begin
            do_end = 1'b1;
        end
        else
        begin
            if (mode != MODE_DRAIN)
            begin
                if (mode == MODE_QPEND)
                begin
                    if (is_quote)
                    begin
                        raw = raw + LEN_W'(2);
                        if (raw >= lim)
                        begin
                            res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_TOO_LONG);
                            mode   = MODE_DRAIN;
                        end
                        else
                        begin
                            res[n] = make_result(KIND_BYTE, CHR_QUOTE, cnt, ERR_NONE);
                            mode   = MODE_QUOTED;
                        end
                        n    = n + 2'd1;
                        done = 1'b1;
                    end
                    else if (raw == '0)
                    begin
                        // closed empty quoted token ends the stream
                        res[n] = make_result(KIND_DONE, 8'd0, cnt, ERR_NONE);
                        n      = n + 2'd1;
                        mode   = MODE_DRAIN;
                        done   = 1'b1;
                    end
                    else
                    begin
                        if (cnt != COUNT_CAP)
                            cnt = cnt + COUNT_W'(1);
                        res[n] = make_result(KIND_END, 8'd0, cnt, ERR_NONE);
                        n      = n + 2'd1;
                        mode   = MODE_SKIP;
                        raw    = '0;
                    end
                end

                if (!done)
                begin
                    case (mode)
                        MODE_SKIP:
                        begin
                            if (!is_sep)
                            begin
                                if (is_quote)
                                begin
                                    raw = '0;
                                    if (lim == '0)
                                    begin
                                        res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_TOO_LONG);
                                        n      = n + 2'd1;
                                        mode   = MODE_DRAIN;
                                    end
                                    else
                                    begin
                                        mode = MODE_QUOTED;
                                    end
                                end
                                else
                                begin
                                    raw = LEN_W'(1);
                                    if (raw >= lim)
                                    begin
                                        res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_TOO_LONG);
                                        mode   = MODE_DRAIN;
                                    end
                                    else
                                    begin
                                        res[n] = make_result(KIND_BYTE, in_byte, cnt, ERR_NONE);
                                        mode   = MODE_PLAIN;
                                    end
                                    n = n + 2'd1;
                                end
                            end
                        end
                        MODE_PLAIN:
                        begin
                            if (is_sep)
                            begin
                                if (cnt != COUNT_CAP)
                                    cnt = cnt + COUNT_W'(1);
                                res[n] = make_result(KIND_END, 8'd0, cnt, ERR_NONE);
                                mode   = MODE_SKIP;
                                raw    = '0;
                            end
                            else
                            begin
                                raw = raw + LEN_W'(1);
                                if (raw >= lim)
                                begin
                                    res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_TOO_LONG);
                                    mode   = MODE_DRAIN;
                                end
                                else
                                begin
                                    res[n] = make_result(KIND_BYTE, in_byte, cnt, ERR_NONE);
                                end
                            end
                            n = n + 2'd1;
                        end
                        MODE_QUOTED:
                        begin
                            if (is_quote)
                            begin
                                mode = MODE_QPEND;
                            end
                            else
                            begin
                                raw = raw + LEN_W'(1);
                                if (raw >= lim)
                                begin
                                    res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_TOO_LONG);
                                    mode   = MODE_DRAIN;
                                end
                                else
                                begin
                                    res[n] = make_result(KIND_BYTE, in_byte, cnt, ERR_NONE);
                                end
                                n = n + 2'd1;
                            end
                        end
                        default:
                        begin
                            mode = MODE_DRAIN;
                        end
                    endcase
                end
            end
            do_end = last;
        end

        if (do_end)
        begin
            case (mode)
                MODE_SKIP:
                begin
                    res[n] = make_result(KIND_DONE, 8'd0, cnt, ERR_NONE);
                    n      = n + 2'd1;
                end
                MODE_PLAIN:
                begin
                    if (cnt != COUNT_CAP)
                        cnt = cnt + COUNT_W'(1);
                    res[n] = make_result(KIND_DONE, 8'd0, cnt, ERR_NONE);
                    n      = n + 2'd1;
                end
                MODE_QUOTED:
                begin
                    res[n] = make_result(KIND_ERR, 8'd0, cnt, ERR_NO_QUOTE);
                    n      = n + 2'd1;
                end
                MODE_QPEND:
                begin
                    if ((raw != '0) && (cnt != COUNT_CAP))
                        cnt = cnt + COUNT_W'(1);
                    res[n] = make_result(KIND_DONE, 8'd0, cnt, ERR_NONE);
                    n      = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode = MODE_SKIP;
            raw  = '0;
            cnt  = '0;
        end

        if (n != 2'd0)
            res[n - 2'd1].last_of_run = 1'b1;

        nxt.mode    = mode;
        nxt.raw_len = raw;
        nxt.tokens  = cnt;
        res_cnt     = n;
    end

endmodule

### hdl/quoted_token_splitter.sv
// ----------------------------------------------------------------------------
// quoted_token_splitter: whitespace/quote tokenizer for a byte stream
// Splits text into tokens and streams token bytes, token ends, done and errors.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per request (tdata) and tlast on the final
//   character of a string; a zero character also ends a string.
//   m_axis returns results: tuser = kind, tdata = byte, count and error code,
//   tlast marks the final result caused by one input character.
//   cfg sets the raw token length limit (reset 4096); write only while idle.
// Latency: an input's first result is valid the cycle after it is accepted.
// Throughput: one input per cycle while each input gives at most one result and
//   m_axis_tready is high; an input giving more results holds s_axis until the
//   single result port has drained the three-entry result buffer to its last entry.
// Reset: parser skips whitespace, token count zero, result buffer empty.
// Stall: when m_axis_tready is low the buffer holds its results and s_axis
//   takes a new request only once the buffer is empty or its last entry leaves.
// ----------------------------------------------------------------------------
module quoted_token_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [7:0] out_byte, [23:8] token_count,
                                                        // [25:24] error_code, rest zero
    output logic [1:0]                  m_axis_tuser,   // [1:0] kind
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [qts_pkg::LEN_W-1:0]   cfg_data
);
    import qts_pkg::*;

    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [LEN_W-1:0] max_len_reg;
    result_t          q_reg [3];
    logic [1:0]       q_cnt_reg;
    result_t          step_res [3];
    logic [1:0]       step_cnt;
    logic             in_fire;
    logic             out_fire;

    qts_step u_step (
        .cur     (state_reg),
        .in_byte (s_axis_tdata),
        .last    (s_axis_tlast),
        .max_len (max_len_reg),
        .nxt     (state_next),
        .res     (step_res),
        .res_cnt (step_cnt)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (q_cnt_reg != 2'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (q_cnt_reg == 2'd0) || ((q_cnt_reg == 2'd1) && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tuser = q_reg[0].kind;
    assign m_axis_tlast = q_reg[0].last_of_run;
    assign m_axis_tdata = {6'd0, q_reg[0].error_code, q_reg[0].token_count, q_reg[0].out_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= MODE_SKIP;
            state_reg.raw_len <= '0;
            state_reg.tokens  <= '0;
            max_len_reg       <= LEN_W'(MAX_TOKEN_LIMIT);
            q_cnt_reg         <= 2'd0;
        end
        else
        begin
            if (cfg_valid)
                max_len_reg <= cfg_data;
            if (in_fire)
            begin
                state_reg <= state_next;
                q_cnt_reg <= step_cnt;
            end
            else if (out_fire)
            begin
                q_cnt_reg <= q_cnt_reg - 2'd1;
            end
        end
    end

    // result buffer payload, entry 0 is the head
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            q_reg <= step_res;
        end
        else if (out_fire)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

endmodule
